@@ rtl/m2es_pkg.sv @@
package m2es_pkg;

    // Lookahead depth and the judging window (lookahead plus one new byte)
    localparam int LOOKAHEAD = 5;
    localparam int WIN_LEN   = LOOKAHEAD + 1;
    localparam int FILL_W    = $clog2(WIN_LEN + 1);
    localparam int IDX_W     = $clog2(WIN_LEN);

    // Bytes needed from the judged position onward for each header match
    localparam logic [FILL_W-1:0] SEQ_SPAN = FILL_W'(4);
    localparam logic [FILL_W-1:0] PIC_SPAN = FILL_W'(6);

    // Start code prefix and ids
    localparam logic [7:0] SC_ZERO  = 8'h00;
    localparam logic [7:0] SC_ONE   = 8'h01;
    localparam logic [7:0] SEQ_CODE = 8'hB3;
    localparam logic [7:0] PIC_CODE = 8'h00;

    // Picture coding types that split a packet
    localparam logic [2:0] PIC_TYPE_P = 3'd2;
    localparam logic [2:0] PIC_TYPE_B = 3'd3;

    typedef enum logic [1:0] {
        PKT_NONE = 2'd0,
        PKT_KEY  = 2'd1,
        PKT_P    = 2'd2,
        PKT_B    = 2'd3
    } pkt_t;

    // Window, entry 0 is the oldest byte
    typedef logic [WIN_LEN-1:0][7:0] win_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_start;
        logic [1:0] packet_kind;
        logic       last_out;
    } out_word_t;

    // Verdict on the oldest window byte
    typedef struct packed {
        logic       emit;
        logic       start;
        pkt_t       next_pkt;
        logic [1:0] kind;
    } judge_t;

endpackage

@@ rtl/mpeg2_es_frame_splitter.sv @@
// Channel   Ports                        Word
// input     s_valid s_ready s_data       data_byte, end_of_stream
// output    m_valid m_ready m_data       out_byte, packet_start, packet_kind, last_out
//
// One byte per clock in steady state while m_ready is high; a byte leaves once five newer bytes are held.
// The oldest byte of a six-byte window register is judged each cycle that the full or
// draining window meets an output register that can take a word, so sustained rate is
// set by that register. After an end-of-stream word, with s_ready low, the window drains
// one byte per free output cycle; then the block is unsynchronized and empty again.
// aresetn is synchronous, active low; it clears fill count, flush flag and state.
// A stalled m_ready holds the output word and back-pressures s_ready when full.
module mpeg2_es_frame_splitter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  m2es_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output m2es_pkg::out_word_t  m_data
);

    localparam logic [m2es_pkg::FILL_W-1:0] FULL = m2es_pkg::FILL_W'(m2es_pkg::WIN_LEN);
    localparam logic [m2es_pkg::FILL_W-1:0] ONE  = m2es_pkg::FILL_W'(1);

    // Window bytes (payload, no reset) and control
    m2es_pkg::win_t               win_reg,   win_next;
    logic [m2es_pkg::FILL_W-1:0]  fill_reg,  fill_next;
    logic                         flush_reg, flush_next;
    m2es_pkg::pkt_t               pkt_reg,   pkt_next;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    m2es_pkg::out_word_t          m_data_reg,  m_data_next;

    m2es_pkg::judge_t             verdict;
    logic                         out_free;
    logic                         adv;
    logic                         accept;
    logic                         flush_done;
    logic [m2es_pkg::FILL_W-1:0]  fill_post;

    // Remaining byte count doubles as match span: six in steady state,
    // shrinking while flushing so start codes past the end do not match.
    m2es_judge u_judge (
        .win     (win_reg),
        .rem     (fill_reg),
        .cur_pkt (pkt_reg),
        .verdict (verdict)
    );

    assign out_free   = !m_valid_reg || m_ready;
    // judge and retire the oldest byte
    assign adv        = out_free && (flush_reg ? (fill_reg != '0) : (fill_reg == FULL));
    assign s_ready    = !flush_reg && ((fill_reg != FULL) || adv);
    assign accept     = s_valid && s_ready;
    assign flush_done = adv && flush_reg && (fill_reg == ONE);
    assign fill_post  = adv ? (fill_reg - ONE) : fill_reg;

    always_comb begin
        win_next   = win_reg;
        fill_next  = fill_post;
        flush_next = flush_reg;
        pkt_next   = pkt_reg;

        if (adv) begin
            for (int i = 0; i < m2es_pkg::WIN_LEN - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[m2es_pkg::WIN_LEN-1] = '0;
            pkt_next = verdict.next_pkt;
        end

        if (accept) begin
            // fill_post is at most five here
            win_next[fill_post[m2es_pkg::IDX_W-1:0]] = s_data.data_byte;
            fill_next = fill_post + ONE;
            if (s_data.end_of_stream) begin
                flush_next = 1'b1;
            end
        end

        // end of stream: back to unsynchronized and empty
        if (flush_done) begin
            flush_next = 1'b0;
            fill_next  = '0;
            pkt_next   = m2es_pkg::PKT_NONE;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (adv && verdict.emit) begin
            m_valid_next              = 1'b1;
            m_data_next.out_byte      = win_reg[0];
            m_data_next.packet_start  = verdict.start;
            m_data_next.packet_kind   = verdict.kind;
            // once synced every later flushed byte is emitted, so last is the last held
            m_data_next.last_out      = flush_done;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            flush_reg   <= 1'b0;
            pkt_reg     <= m2es_pkg::PKT_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            flush_reg   <= flush_next;
            pkt_reg     <= pkt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg    <= win_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/m2es_judge.sv @@
module m2es_judge (
    input  m2es_pkg::win_t                 win,
    input  logic [m2es_pkg::FILL_W-1:0]    rem,
    input  m2es_pkg::pkt_t                 cur_pkt,
    output m2es_pkg::judge_t               verdict
);

    logic       prefix;
    logic       seq;
    logic       pic;
    logic       pb;
    logic [2:0] coding_type;

    // 00 00 01 at the oldest position
    assign prefix      = (win[0] == m2es_pkg::SC_ZERO) && (win[1] == m2es_pkg::SC_ZERO)
                      && (win[2] == m2es_pkg::SC_ONE);
    assign seq         = (rem >= m2es_pkg::SEQ_SPAN) && prefix
                      && (win[3] == m2es_pkg::SEQ_CODE);
    assign pic         = (rem >= m2es_pkg::PIC_SPAN) && prefix
                      && (win[3] == m2es_pkg::PIC_CODE);
    assign coding_type = win[5][5:3];
    assign pb          = pic && ((coding_type == m2es_pkg::PIC_TYPE_P)
                              || (coding_type == m2es_pkg::PIC_TYPE_B));

    always_comb begin
        verdict.start    = 1'b0;
        verdict.next_pkt = cur_pkt;
        unique case (cur_pkt)
            m2es_pkg::PKT_NONE: begin
                if (seq) begin
                    verdict.next_pkt = m2es_pkg::PKT_KEY;
                    verdict.start    = 1'b1;
                end
            end
            m2es_pkg::PKT_KEY: begin
                // a repeated sequence header stays inside the keyframe
                if (pb) begin
                    verdict.next_pkt = m2es_pkg::pkt_t'(coding_type[1:0]);
                    verdict.start    = 1'b1;
                end
            end
            default: begin
                if (seq) begin
                    verdict.next_pkt = m2es_pkg::PKT_KEY;
                    verdict.start    = 1'b1;
                end else if (pb) begin
                    verdict.next_pkt = m2es_pkg::pkt_t'(coding_type[1:0]);
                    verdict.start    = 1'b1;
                end
            end
        endcase
        verdict.emit = (verdict.next_pkt != m2es_pkg::PKT_NONE);
        verdict.kind = 2'(verdict.next_pkt - m2es_pkg::PKT_KEY);
    end

endmodule
